@@ hdl/ictf_pkg.sv @@
package ictf_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int STEP_W       = $clog2(ATAN_LEN);
    localparam int SQRT_STEPS   = 24;
    localparam int SQRT_CNT_W   = $clog2(SQRT_STEPS);
    localparam int CW           = 42;
    localparam int ZW           = 35;
    localparam int MW           = 25;
    localparam int PW           = 2 * MW;

    localparam int DEG_60  = 15360;
    localparam int DEG_90  = 23040;
    localparam int DEG_180 = 46080;
    localparam int DEG_360 = 92160;

    localparam logic signed [ZW-1:0] HALF_TURN_FINE = 35'sd3019898880;
    localparam logic [23:0] RECIP_125  = 24'd8589935;
    localparam logic [22:0] GYRO_BIAS  = 23'd62;
    localparam logic [6:0]  DT_DEFAULT = 7'd10;
    localparam logic [31:0] DT_MAX     = 32'd100;

    localparam logic [15:0] ALPHA_RESET    = 16'd64225;
    localparam logic [11:0] DEADBAND_RESET = 12'd16;

    localparam logic CFG_ALPHA    = 1'b0;
    localparam logic CFG_DEADBAND = 1'b1;
    localparam logic MODE_SAMPLE  = 1'b0;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        logic [6:0]         dt;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

    typedef struct packed {
        logic                  start;
        logic signed [MW-1:0]  y;
        logic signed [MW-1:0]  x;
    } t_cordic_req;

    typedef struct packed {
        logic        start;
        logic [47:0] value;
    } t_sqrt_req;

    typedef enum logic [4:0] {
        ST_IDLE, ST_ZERO, ST_SQ_A, ST_SQ_B, ST_SQ_C,
        ST_GY_A, ST_GY_B, ST_GY_C, ST_GX_A, ST_GX_B, ST_GX_C,
        ST_WAIT_P, ST_WAIT_R,
        ST_BP_A, ST_BP_B, ST_BP_C, ST_BR_A, ST_BR_B, ST_BR_C,
        ST_OUT
    } t_back_state;

    function automatic logic [29:0] atan_fine(input logic [STEP_W-1:0] i);
        case (i)
            5'd0:    return 30'd754974720;
            5'd1:    return 30'd445687602;
            5'd2:    return 30'd235489088;
            5'd3:    return 30'd119537938;
            5'd4:    return 30'd60000934;
            5'd5:    return 30'd30029717;
            5'd6:    return 30'd15018523;
            5'd7:    return 30'd7509720;
            5'd8:    return 30'd3754917;
            5'd9:    return 30'd1877466;
            5'd10:   return 30'd938734;
            5'd11:   return 30'd469367;
            5'd12:   return 30'd234684;
            5'd13:   return 30'd117342;
            5'd14:   return 30'd58671;
            5'd15:   return 30'd29335;
            5'd16:   return 30'd14668;
            5'd17:   return 30'd7334;
            5'd18:   return 30'd3667;
            5'd19:   return 30'd1833;
            5'd20:   return 30'd917;
            5'd21:   return 30'd458;
            5'd22:   return 30'd229;
            5'd23:   return 30'd115;
            default: return 30'd0;
        endcase
    endfunction

endpackage

@@ hdl/ictf_in_if.sv @@
interface ictf_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic [31:0]        timestamp_ms;

    modport source(output valid, mode, accel_x, accel_y, accel_z, gyro_x, gyro_y,
                   timestamp_ms, input ready);
    modport sink(input valid, mode, accel_x, accel_y, accel_z, gyro_x, gyro_y,
                 timestamp_ms, output ready);
endinterface

@@ hdl/ictf_out_if.sv @@
interface ictf_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] pitch_angle;
    logic signed [16:0] roll_angle;
    logic signed [14:0] shown_pitch;
    logic signed [15:0] shown_roll;

    modport source(output valid, pitch_angle, roll_angle, shown_pitch, shown_roll,
                   input ready);
    modport sink(input valid, pitch_angle, roll_angle, shown_pitch, shown_roll,
                 output ready);
endinterface

@@ hdl/ictf_front.sv @@
module ictf_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ictf_in_if.sink               i_sample,
    input  ictf_pkg::t_fifo_status i_fifo,
    output logic                  o_push,
    output ictf_pkg::t_job        o_job
);
    import ictf_pkg::*;

    logic [31:0] r_prev_time;
    logic [31:0] diff;

    assign diff           = i_sample.timestamp_ms - r_prev_time;
    assign i_sample.ready = !i_fifo.full;
    assign o_push         = i_sample.valid && !i_fifo.full;

    always_comb begin
        o_job.mode = i_sample.mode;
        o_job.ax   = i_sample.accel_x;
        o_job.ay   = i_sample.accel_y;
        o_job.az   = i_sample.accel_z;
        o_job.gx   = i_sample.gyro_x;
        o_job.gy   = i_sample.gyro_y;
        o_job.dt   = (diff == 32'd0 || diff > DT_MAX) ? DT_DEFAULT : diff[6:0];
    end

    // only sensor samples advance the time base
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_time <= 32'd0;
        end else if (o_push && i_sample.mode == MODE_SAMPLE) begin
            r_prev_time <= i_sample.timestamp_ms;
        end
    end
endmodule

@@ hdl/ictf_fifo.sv @@
module ictf_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  ictf_pkg::t_job         i_job,
    input  logic                   i_pop,
    output ictf_pkg::t_job         o_job,
    output ictf_pkg::t_fifo_status o_stat
);
    import ictf_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_job        = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end
endmodule

@@ hdl/ictf_sqrt.sv @@
module ictf_sqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ictf_pkg::t_sqrt_req i_req,
    output logic                o_busy,
    output logic [23:0]         o_root
);
    import ictf_pkg::*;

    logic [47:0]           r_val;
    logic [27:0]           r_rem;
    logic [23:0]           r_root;
    logic [SQRT_CNT_W-1:0] r_cnt;
    logic                  r_busy;
    logic [27:0]           rem_t;
    logic [27:0]           trial;

    assign o_busy = r_busy;
    assign o_root = r_root;
    assign rem_t  = {r_rem[25:0], r_val[47:46]};
    assign trial  = {2'b00, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_val  <= i_req.value;
            r_rem  <= 28'd0;
            r_root <= 24'd0;
        end else if (r_busy) begin
            r_val <= {r_val[45:0], 2'b00};
            if (rem_t >= trial) begin
                r_rem  <= rem_t - trial;
                r_root <= {r_root[22:0], 1'b1};
            end else begin
                r_rem  <= rem_t;
                r_root <= {r_root[22:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end
endmodule

@@ hdl/ictf_cordic.sv @@
module ictf_cordic (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ictf_pkg::t_cordic_req i_req,
    output logic                  o_busy,
    output logic signed [16:0]    o_angle
);
    import ictf_pkg::*;

    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    logic [STEP_W-1:0]    r_step;
    logic                 r_busy;
    logic                 r_null;
    logic signed [CW-1:0] x_in;
    logic signed [CW-1:0] y_in;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] at;
    logic signed [ZW-1:0] rz;

    assign x_in = CW'(i_req.x);
    assign y_in = CW'(i_req.y);
    assign dx   = r_y >>> r_step;
    assign dy   = r_x >>> r_step;
    assign at   = $signed({5'b00000, atan_fine(r_step)});
    assign rz   = (r_z + ZW'(32768)) >>> 16;
    assign o_busy = r_busy;

    always_comb begin
        if (r_null) begin
            o_angle = 17'sd0;
        end else if (rz > ZW'(DEG_180)) begin
            o_angle = 17'(DEG_180);
        end else if (rz < -ZW'(DEG_180)) begin
            o_angle = -17'(DEG_180);
        end else begin
            o_angle = 17'(rz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_null <= (i_req.x == '0) && (i_req.y == '0);
            if (i_req.x < 0) begin
                r_x <= (-x_in) <<< 12;
                r_y <= (-y_in) <<< 12;
                r_z <= (i_req.y >= 0) ? HALF_TURN_FINE : -HALF_TURN_FINE;
            end else begin
                r_x <= x_in <<< 12;
                r_y <= y_in <<< 12;
                r_z <= '0;
            end
        end else if (r_busy) begin
            if (r_y > 0) begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end else begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end
endmodule

@@ hdl/ictf_back.sv @@
module ictf_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ictf_pkg::t_job         i_job,
    input  ictf_pkg::t_fifo_status i_fifo,
    output logic                   o_pop,
    input  logic [15:0]            i_alpha,
    input  logic [11:0]            i_deadband,
    output ictf_pkg::t_cordic_req  o_cordic,
    input  logic                   i_cordic_busy,
    input  logic signed [16:0]     i_cordic_angle,
    output ictf_pkg::t_sqrt_req    o_sqrt,
    input  logic                   i_sqrt_busy,
    input  logic [23:0]            i_sqrt_root,
    ictf_out_if.source             o_result
);
    import ictf_pkg::*;

    t_back_state           r_state;
    t_back_state           n_state;
    t_job                  r_job;
    logic signed [PW-1:0]  r_prod;
    logic signed [PW-1:0]  r_acc;
    logic [31:0]           r_sum;
    logic signed [18:0]    r_gp;
    logic signed [18:0]    r_gr;
    logic signed [16:0]    r_ap;
    logic signed [16:0]    r_ar;
    logic signed [16:0]    r_filt_p;
    logic signed [16:0]    r_filt_r;
    logic signed [16:0]    r_zero_p;
    logic signed [16:0]    r_zero_r;
    logic                  r_out_valid;
    logic signed [16:0]    r_out_pitch;
    logic signed [16:0]    r_out_roll;
    logic signed [14:0]    r_out_shp;
    logic signed [15:0]    r_out_shr;

    logic signed [MW-1:0]  mul_a;
    logic signed [MW-1:0]  mul_b;
    logic [22:0]           recip_in;
    logic [16:0]           alpha_c;
    logic signed [PW-1:0]  blend_sum;
    logic                  out_free;
    logic                  out_load;
    logic [31:0]           sq_sum;

    function automatic logic [16:0] mag_of(input logic signed [15:0] rate);
        logic signed [16:0] r17;
        r17 = 17'(rate);
        return rate[15] ? 17'(17'sd0 - r17) : 17'(r17);
    endfunction

    function automatic logic signed [17:0] gyro_inc(input logic signed [15:0] rate,
                                                    input logic [16:0] q,
                                                    input logic [11:0] db);
        if (mag_of(rate) < {5'd0, db}) begin
            return 18'sd0;
        end
        return rate[15] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    function automatic logic signed [17:0] unwrap(input logic signed [18:0] g,
                                                  input logic signed [16:0] a);
        logic signed [19:0] gg;
        logic signed [19:0] d;
        gg = 20'(g);
        d  = gg - 20'(a);
        if (d > 20'(DEG_180)) begin
            gg = gg - 20'(DEG_360);
        end else if (d < -20'(DEG_180)) begin
            gg = gg + 20'(DEG_360);
        end
        return 18'(gg);
    endfunction

    function automatic logic signed [16:0] blend_done(input logic signed [PW-1:0] s);
        logic signed [PW-1:0] t;
        logic signed [19:0]   w;
        t = s >>> 16;
        w = 20'(t);
        if (w > 20'(DEG_180)) begin
            w = w - 20'(DEG_360);
        end else if (w < -20'(DEG_180)) begin
            w = w + 20'(DEG_360);
        end
        return 17'(w);
    endfunction

    function automatic logic signed [16:0] shown(input logic signed [16:0] f,
                                                 input logic signed [16:0] z,
                                                 input int lim);
        logic signed [17:0] d;
        d = 18'(f) - 18'(z);
        if (d > 18'(DEG_180)) begin
            d = d - 18'(DEG_360);
        end else if (d < -18'(DEG_180)) begin
            d = d + 18'(DEG_360);
        end
        if (d > 18'(lim)) begin
            d = 18'(lim);
        end else if (d < -18'(lim)) begin
            d = -18'(lim);
        end
        return 17'(d);
    endfunction

    assign recip_in  = 23'({r_prod[21:0], 1'b0}) + GYRO_BIAS;
    assign alpha_c   = 17'd65536 - {1'b0, i_alpha};
    assign blend_sum = r_acc + r_prod + PW'(32768);
    assign out_free  = !r_out_valid || o_result.ready;
    assign sq_sum    = r_sum + r_prod[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_pop           = 1'b0;
        out_load        = 1'b0;
        o_cordic.start  = 1'b0;
        o_cordic.y      = -(MW'(r_job.ax) <<< 8);
        o_cordic.x      = MW'(r_job.az) <<< 8;
        o_sqrt.start    = 1'b0;
        o_sqrt.value    = {sq_sum, 16'd0};
        mul_a           = '0;
        mul_b           = '0;
        case (r_state)
            ST_IDLE: begin
                if (!i_fifo.empty) begin
                    o_pop   = 1'b1;
                    n_state = (i_job.mode == MODE_SAMPLE) ? ST_SQ_A : ST_ZERO;
                end
            end
            ST_ZERO: n_state = ST_OUT;
            ST_SQ_A: begin
                mul_a   = MW'(r_job.ax);
                mul_b   = MW'(r_job.ax);
                n_state = ST_SQ_B;
            end
            ST_SQ_B: begin
                mul_a   = MW'(r_job.az);
                mul_b   = MW'(r_job.az);
                n_state = ST_SQ_C;
            end
            ST_SQ_C: begin
                o_sqrt.start   = 1'b1;
                o_cordic.start = 1'b1;
                n_state        = ST_GY_A;
            end
            ST_GY_A, ST_GX_A: begin
                mul_a   = $signed({8'd0, mag_of((r_state == ST_GY_A) ? r_job.gy : r_job.gx)});
                mul_b   = $signed({18'd0, r_job.dt});
                n_state = (r_state == ST_GY_A) ? ST_GY_B : ST_GX_B;
            end
            ST_GY_B, ST_GX_B: begin
                mul_a   = $signed({2'b00, recip_in});
                mul_b   = $signed({1'b0, RECIP_125});
                n_state = (r_state == ST_GY_B) ? ST_GY_C : ST_GX_C;
            end
            ST_GY_C: n_state = ST_GX_A;
            ST_GX_C: n_state = ST_WAIT_P;
            ST_WAIT_P: begin
                o_cordic.y = -(MW'(r_job.ay) <<< 8);
                o_cordic.x = $signed({1'b0, i_sqrt_root});
                if (!i_cordic_busy && !i_sqrt_busy) begin
                    o_cordic.start = 1'b1;
                    n_state        = ST_WAIT_R;
                end
            end
            ST_WAIT_R: begin
                if (!i_cordic_busy) begin
                    n_state = ST_BP_A;
                end
            end
            ST_BP_A: begin
                mul_a   = $signed({9'd0, i_alpha});
                mul_b   = MW'(unwrap(r_gp, r_ap));
                n_state = ST_BP_B;
            end
            ST_BP_B: begin
                mul_a   = $signed({8'd0, alpha_c});
                mul_b   = MW'(r_ap);
                n_state = ST_BP_C;
            end
            ST_BP_C: n_state = ST_BR_A;
            ST_BR_A: begin
                mul_a   = $signed({9'd0, i_alpha});
                mul_b   = MW'(unwrap(r_gr, r_ar));
                n_state = ST_BR_B;
            end
            ST_BR_B: begin
                mul_a   = $signed({8'd0, alpha_c});
                mul_b   = MW'(r_ar);
                n_state = ST_BR_C;
            end
            ST_BR_C: n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (o_pop) begin
            r_job <= i_job;
        end
        case (r_state)
            ST_SQ_B: r_sum <= r_prod[31:0];
            ST_SQ_C: r_sum <= sq_sum;
            ST_GY_C: r_gp  <= 19'(r_filt_p) + 19'(gyro_inc(r_job.gy, r_prod[46:30], i_deadband));
            ST_GX_C: r_gr  <= 19'(r_filt_r) - 19'(gyro_inc(r_job.gx, r_prod[46:30], i_deadband));
            ST_WAIT_P: begin
                if (!i_cordic_busy && !i_sqrt_busy) begin
                    r_ap <= i_cordic_angle;
                end
            end
            ST_WAIT_R: begin
                if (!i_cordic_busy) begin
                    r_ar <= i_cordic_angle;
                end
            end
            ST_BP_B, ST_BR_B: r_acc <= r_prod;
            default: begin
            end
        endcase
        if (out_load) begin
            r_out_pitch <= r_filt_p;
            r_out_roll  <= r_filt_r;
            r_out_shp   <= 15'(shown(r_filt_p, r_zero_p, DEG_60));
            r_out_shr   <= 16'(shown(r_filt_r, r_zero_r, DEG_90));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt_p    <= 17'sd0;
            r_filt_r    <= 17'sd0;
            r_zero_p    <= 17'sd0;
            r_zero_r    <= 17'sd0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_ZERO) begin
                r_zero_p <= r_filt_p;
                r_zero_r <= r_filt_r;
            end
            if (r_state == ST_BP_C) begin
                r_filt_p <= blend_done(blend_sum);
            end
            if (r_state == ST_BR_C) begin
                r_filt_r <= blend_done(blend_sum);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.pitch_angle = r_out_pitch;
    assign o_result.roll_angle  = r_out_roll;
    assign o_result.shown_pitch = r_out_shp;
    assign o_result.shown_roll  = r_out_shr;
endmodule

@@ hdl/imu_complementary_tilt_filter_top.sv @@
// the back end takes one job at a time, popping the next after its result is loaded
// into a free output; a sample's time is set by the 24-step square root that runs
// beside the pitch cordic pass, then the 16-step roll cordic pass and the blend steps;
// a zero request skips these steps; a two-entry queue decouples input
// reset: synchronous active low, clears angles, offsets, time base and queue,
// and loads the register defaults
module imu_complementary_tilt_filter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ictf_in_if.sink     i_sample,
    ictf_out_if.source  o_result,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import ictf_pkg::*;

    logic [15:0]        r_alpha;
    logic [11:0]        r_deadband;
    logic               push;
    logic               pop;
    t_job               front_job;
    t_job               queue_job;
    t_fifo_status       fifo_stat;
    t_cordic_req        cordic_req;
    t_sqrt_req          sqrt_req;
    logic               cordic_busy;
    logic signed [16:0] cordic_angle;
    logic               sqrt_busy;
    logic [23:0]        sqrt_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha    <= ALPHA_RESET;
            r_deadband <= DEADBAND_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ALPHA:    r_alpha    <= i_cfg_data;
                CFG_DEADBAND: r_deadband <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    ictf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sample(i_sample),
        .i_fifo  (fifo_stat),
        .o_push  (push),
        .o_job   (front_job)
    );

    ictf_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (front_job),
        .i_pop  (pop),
        .o_job  (queue_job),
        .o_stat (fifo_stat)
    );

    ictf_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (sqrt_req),
        .o_busy (sqrt_busy),
        .o_root (sqrt_root)
    );

    ictf_cordic u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (cordic_req),
        .o_busy (cordic_busy),
        .o_angle(cordic_angle)
    );

    ictf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (queue_job),
        .i_fifo        (fifo_stat),
        .o_pop         (pop),
        .i_alpha       (r_alpha),
        .i_deadband    (r_deadband),
        .o_cordic      (cordic_req),
        .i_cordic_busy (cordic_busy),
        .i_cordic_angle(cordic_angle),
        .o_sqrt        (sqrt_req),
        .i_sqrt_busy   (sqrt_busy),
        .i_sqrt_root   (sqrt_root),
        .o_result      (o_result)
    );

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_stat.full |-> !push) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !fifo_stat.empty) else $error("pop from empty queue");
    a_cordic_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cordic_req.start |-> !cordic_busy) else $error("cordic restarted while busy");
    a_sqrt_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_req.start |=> sqrt_busy) else $error("sqrt did not start");
`endif
endmodule

@@ dv/imu_complementary_tilt_filter_top_tb.sv @@
module imu_complementary_tilt_filter_top_tb;
    import ictf_pkg::*;

    typedef struct {
        bit        mode;
        bit [15:0] ax;
        bit [15:0] ay;
        bit [15:0] az;
        bit [15:0] gx;
        bit [15:0] gy;
        bit [31:0] ts;
    } t_sample;

    typedef struct {
        bit [16:0] pitch;
        bit [16:0] roll;
        bit [14:0] sh_pitch;
        bit [15:0] sh_roll;
    } t_angles;

    localparam int FB = 8;
    localparam longint ONE_DEG = 256;
    localparam longint HALF_TURN = 180 * ONE_DEG;
    localparam longint FULL_TURN = 360 * ONE_DEG;
    localparam longint HALF_FINE = 64'sd3019898880;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic [15:0] i_cfg_data;

    ictf_in_if  sample_ch();
    ictf_out_if result_ch();

    imu_complementary_tilt_filter_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (sample_ch),
        .o_result   (result_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    t_sample pending_q[$];
    t_angles expected_q[$];
    int      error_count = 0;
    bit      drv_quiet = 0;
    bit      mon_quiet = 0;

    longint  m_alpha;
    longint  m_deadband;
    longint  m_pitch;
    longint  m_roll;
    longint  m_zero_pitch;
    longint  m_zero_roll;
    bit [31:0] m_prev_ms;

    longint atan_tab[24] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint floor_sh(longint v, int s);
        if (v >= 0) return v >>> s;
        return -((-v + ((64'sd1 <<< s) - 1)) >>> s);
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint tilt_atan2(longint y, longint x);
        longint z, dx, dy, r;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? HALF_FINE : -HALF_FINE;
            x = -x;
            y = -y;
        end
        x *= 4096;
        y *= 4096;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = floor_sh(y, i);
            dy = floor_sh(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += atan_tab[i];
            end else begin
                x -= dx; y += dy; z -= atan_tab[i];
            end
        end
        r = floor_sh(z + (64'sd1 <<< (23 - FB)), 24 - FB);
        if (r > HALF_TURN) r = HALF_TURN;
        if (r < -HALF_TURN) r = -HALF_TURN;
        return r;
    endfunction

    function automatic longint wrap_angle(longint a);
        while (a > HALF_TURN) a -= FULL_TURN;
        while (a < -HALF_TURN) a += FULL_TURN;
        return a;
    endfunction

    function automatic longint gyro_increment(longint rate, longint dt);
        longint mag, q;
        mag = rate < 0 ? -rate : rate;
        if (mag < m_deadband) return 0;
        q = (mag * dt * ONE_DEG + 8000) / 16000;
        return rate < 0 ? -q : q;
    endfunction

    function automatic longint fuse(longint g, longint a);
        if (g - a > HALF_TURN) g -= FULL_TURN;
        else if (g - a < -HALF_TURN) g += FULL_TURN;
        g = floor_sh(m_alpha * g + (65536 - m_alpha) * a + 32768, 16);
        return wrap_angle(g);
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic t_angles predict_angles(t_sample s);
        t_angles o;
        longint ax, ay, az, gx, gy, dt, ap, ar;
        bit [31:0] diff;
        longint unsigned sq;
        if (s.mode != MODE_SAMPLE) begin
            m_zero_pitch = m_pitch;
            m_zero_roll = m_roll;
        end else begin
            ax = longint'($signed(s.ax));
            ay = longint'($signed(s.ay));
            az = longint'($signed(s.az));
            gx = longint'($signed(s.gx));
            gy = longint'($signed(s.gy));
            diff = s.ts - m_prev_ms;
            dt = (diff == 0 || diff > 100) ? 10 : longint'(diff);
            m_prev_ms = s.ts;
            ap = tilt_atan2(-ax * 256, az * 256);
            sq = (ax * ax + az * az) << 16;
            ar = tilt_atan2(-ay * 256, int_sqrt(sq));
            m_pitch = fuse(m_pitch + gyro_increment(gy, dt), ap);
            m_roll = fuse(m_roll - gyro_increment(gx, dt), ar);
        end
        o.pitch = m_pitch[16:0];
        o.roll = m_roll[16:0];
        o.sh_pitch = 15'(clip(wrap_angle(m_pitch - m_zero_pitch), 60 * ONE_DEG));
        o.sh_roll = 16'(clip(wrap_angle(m_roll - m_zero_roll), 90 * ONE_DEG));
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // driver
    always @(posedge i_clk) begin
        t_sample s;
        if (!i_rst_n) begin
            sample_ch.valid <= 1'b0;
        end else if (!sample_ch.valid || sample_ch.ready) begin
            if (pending_q.size() > 0 && (drv_quiet || $urandom_range(99) >= 8)) begin
                s = pending_q.pop_front();
                expected_q.push_back(predict_angles(s));
                sample_ch.valid        <= 1'b1;
                sample_ch.mode         <= s.mode;
                sample_ch.accel_x      <= s.ax;
                sample_ch.accel_y      <= s.ay;
                sample_ch.accel_z      <= s.az;
                sample_ch.gyro_x       <= s.gx;
                sample_ch.gyro_y       <= s.gy;
                sample_ch.timestamp_ms <= s.ts;
            end else begin
                sample_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_angles w;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected transfer", 1, 0);
                end else begin
                    w = expected_q.pop_front();
                    if (result_ch.pitch_angle !== w.pitch)
                        report_mismatch("pitch_angle", result_ch.pitch_angle,
                                        $signed(w.pitch));
                    if (result_ch.roll_angle !== w.roll)
                        report_mismatch("roll_angle", result_ch.roll_angle,
                                        $signed(w.roll));
                    if (result_ch.shown_pitch !== w.sh_pitch)
                        report_mismatch("shown_pitch", result_ch.shown_pitch,
                                        $signed(w.sh_pitch));
                    if (result_ch.shown_roll !== w.sh_roll)
                        report_mismatch("shown_roll", result_ch.shown_roll,
                                        $signed(w.sh_roll));
                end
            end
            result_ch.ready <= mon_quiet || $urandom_range(99) >= 8;
        end
    end

    function automatic bit [15:0] pick16();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic bit [15:0] pick_rate();
        case ($urandom_range(3))
            0: return 16'(int'($urandom_range(80)) - 40);
            1: return 16'($urandom);
            default: return 16'(int'($urandom_range(4000)) - 2000);
        endcase
    endfunction

    bit [31:0] clock_ms;

    task automatic add_item(bit md, bit [15:0] ax, bit [15:0] ay, bit [15:0] az,
                            bit [15:0] gx, bit [15:0] gy, bit [31:0] ts);
        t_sample s;
        s.mode = md; s.ax = ax; s.ay = ay; s.az = az; s.gx = gx; s.gy = gy; s.ts = ts;
        pending_q.push_back(s);
    endtask

    task automatic add_random(int count);
        bit [31:0] ts;
        repeat (count) begin
            case ($urandom_range(9))
                0: ts = $urandom;
                1: ts = clock_ms;
                2: ts = clock_ms + $urandom_range(500, 101);
                default: ts = clock_ms + $urandom_range(100, 1);
            endcase
            clock_ms = ts;
            add_item($urandom_range(19) == 0, pick16(), pick16(), pick16(),
                     pick_rate(), pick_rate(), ts);
        end
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || expected_q.size() > 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(bit idx, bit [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ALPHA) m_alpha = data;
        else m_deadband = data[11:0];
    endtask

    initial begin
        m_alpha = ALPHA_RESET;
        m_deadband = DEADBAND_RESET;
        m_pitch = 0; m_roll = 0; m_zero_pitch = 0; m_zero_roll = 0; m_prev_ms = 0;
        clock_ms = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = 1'b0;
        i_cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.mode = 1'b0;
        sample_ch.accel_x = '0;
        sample_ch.accel_y = '0;
        sample_ch.accel_z = '0;
        sample_ch.gyro_x = '0;
        sample_ch.gyro_y = '0;
        sample_ch.timestamp_ms = '0;
        result_ch.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero vector, extremes, time fallback, offsets
        add_item(0, 0, 0, 0, 0, 0, 0);
        add_item(0, 0, 0, 16'd1000, 0, 0, 20);
        add_item(0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 30);
        add_item(0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 130);
        add_item(0, 16'h7fff, 0, 16'h8000, 16'd15, 16'hfff1, 131);
        add_item(0, 16'h8000, 16'h7fff, 16'h8001, 16'd16, 16'hfff0, 231);
        add_item(1, 16'h1234, 16'h4321, 0, 0, 0, 32'hffffffff);
        add_item(0, 0, 16'd500, 16'hfc00, 16'd400, 16'hfe70, 231);
        add_item(0, 16'd300, 16'hfed4, 0, 16'h7fff, 16'h7fff, 32'hffffff00);
        add_item(0, 0, 0, 16'hff00, 0, 0, 32'hffffff10);
        add_item(0, 0, 16'h8000, 0, 16'h8000, 16'h7fff, 32'h00000010);
        add_item(1, 0, 0, 0, 0, 0, 0);
        add_item(0, 16'hffff, 16'h0001, 16'hffff, 16'hfff0, 16'h0010, 32'h00000074);
        clock_ms = 32'h74;
        add_random(300);
        mon_quiet = 1; drv_quiet = 1;
        add_random(200);
        drain();
        mon_quiet = 0; drv_quiet = 0;

        write_reg(CFG_ALPHA, 16'd0);
        write_reg(CFG_DEADBAND, 16'd0);
        add_random(250);
        drain();
        write_reg(CFG_ALPHA, 16'hffff);
        write_reg(CFG_DEADBAND, 16'hfff);
        add_random(250);
        drain();
        write_reg(CFG_ALPHA, 16'd32768);
        write_reg(CFG_DEADBAND, 16'd100);
        add_random(500);
        drain();
        write_reg(CFG_ALPHA, 16'($urandom));
        write_reg(CFG_DEADBAND, 16'($urandom_range(4095)));
        add_random(500);
        drain();

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #10000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ imu_complementary_tilt_filter_top.f @@
hdl/ictf_pkg.sv
hdl/ictf_in_if.sv
hdl/ictf_out_if.sv
hdl/ictf_front.sv
hdl/ictf_fifo.sv
hdl/ictf_sqrt.sv
hdl/ictf_cordic.sv
hdl/ictf_back.sv
hdl/imu_complementary_tilt_filter_top.sv
dv/imu_complementary_tilt_filter_top_tb.sv
